FILE: src/kftl_pkg.sv
package kftl_pkg;

    // stream payload widths
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 96;
    localparam int COMP_W      = 32;
    localparam int FRAC_W      = 16;

    // item kinds carried on s_tuser
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SEARCH = 7'b0000010,
        ST_DIV    = 7'b0000100,
        ST_MUL    = 7'b0001000,
        ST_FETCH  = 7'b0010000,
        ST_LOAD   = 7'b0100000,
        ST_OUT    = 7'b1000000
    } kftl_state_t;

endpackage

FILE: src/keyframe_track_lerp.sv
// Keyframe track with linear interpolation.
// Input stream (s_*): s_tuser selects the transfer kind. A write transfer stores
// key_time and key_x/y/z in slot key_index (slots at or above KEYS are dropped)
// and yields no result. A query transfer evaluates the track at query_time and
// yields one result on m_* (x, y, z in Q16.16, m_tuser flags a clamped query).
// cfg_we/cfg_wdata set the key count; write it only while the block is idle.
// A write is stored as it is accepted and leaves the sequencer idle. A query with
// one key goes through fetch, load and out. Otherwise the key times are scanned
// one per cycle from the time memory; an in-range query then runs a restoring
// divide for the Q0.16 factor, then goes through one shared 33x17 multiplier for
// the three components. Clamped queries go from the scan through fetch, load and
// out.
// s_tready is high only while the sequencer is idle. The result sits in an output
// register, so a new item is accepted while m_tvalid waits on m_tready; a finished
// query holds in its last step until that register frees up.
// Reset clears the sequencer, the output valid and sets the key count to 1; the
// key memories keep their contents and must be written before use.
module keyframe_track_lerp
    import kftl_pkg::*;
#(
    parameter int KEYS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration: num_keys
    input  logic                   cfg_we,
    input  logic [4:0]             cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // key_index[3:0], key_time[35:4], key_x[67:36], key_y[99:68], key_z[131:100],
    // query_time[163:132], zero fill [167:164]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // kind[0]
    input  logic                   s_tuser,
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // out_of_range[0]
    output logic                   m_tuser
);

    localparam int IW = $clog2(KEYS);
    localparam int NW = $clog2(KEYS + 1);

    // input fields
    logic [3:0]        in_key_index;
    logic [31:0]       in_key_time;
    logic [95:0]       in_key_value;
    logic [31:0]       in_query_time;

    assign in_key_index  = s_tdata[3:0];
    assign in_key_time   = s_tdata[35:4];
    assign in_key_value  = s_tdata[131:36];
    assign in_query_time = s_tdata[163:132];

    // key memories
    logic [31:0]       time_mem [KEYS];
    logic [95:0]       value_mem [KEYS];
    logic [31:0]       time_rd_reg;
    logic [95:0]       value_rd_reg;
    logic [IW-1:0]     t_addr;
    logic [IW-1:0]     v_addr;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;

    // control and datapath registers
    kftl_state_t       state_reg, state_next;
    logic [4:0]        num_keys_reg, num_keys_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [31:0]       q_reg, q_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic [IW-1:0]     seg_reg, seg_next;
    logic [31:0]       prev_reg, prev_next;
    logic [31:0]       rem_reg, rem_next;
    logic [31:0]       delta_reg, delta_next;
    logic [15:0]       quo_reg, quo_next;
    logic [3:0]        div_cnt_reg, div_cnt_next;
    logic [2:0]        mul_cnt_reg, mul_cnt_next;
    logic [95:0]       a_reg, a_next;
    logic [95:0]       b_reg, b_next;
    logic signed [32:0] d_reg, d_next;
    logic signed [49:0] prod_reg, prod_next;
    logic [95:0]       res_reg, res_next;
    logic              oor_reg, oor_next;
    logic              m_valid_reg, m_valid_next;
    logic [95:0]       m_data_reg, m_data_next;
    logic              m_user_reg, m_user_next;

    // helpers
    logic              s_xfer;
    logic [NW-1:0]     n_eff;
    logic [NW-1:0]     cnt_ext;
    logic [32:0]       rem_dbl;
    logic [31:0]       a_sub, b_sub, a_res;
    logic [1:0]        res_idx;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // effective key count, 0 acts as 1 and large counts clamp to KEYS
    always_comb
    begin
        if (num_keys_reg == 5'd0)
            n_eff = NW'(1);
        else if (32'(num_keys_reg) > KEYS)
            n_eff = NW'(KEYS);
        else
            n_eff = NW'(num_keys_reg);
    end

    assign cnt_ext   = NW'(cnt_reg);
    assign mem_we    = s_xfer && (s_tuser == KIND_WRITE) && (32'(in_key_index) < KEYS);
    assign mem_waddr = IW'(in_key_index);

    // time read address: slot 0 on accept, then one ahead of the compare
    always_comb
    begin
        if (state_reg == ST_SEARCH && (cnt_ext + NW'(1)) < n_reg)
            t_addr = cnt_reg + IW'(1);
        else if (state_reg == ST_SEARCH)
            t_addr = cnt_reg;
        else
            t_addr = '0;
    end

    // value read address: start key, then end key during the divide
    always_comb
    begin
        if (state_reg == ST_DIV && div_cnt_reg != 4'd0)
            v_addr = seg_reg + IW'(1);
        else
            v_addr = seg_reg;
    end

    // key memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            time_mem[mem_waddr]  <= in_key_time;
            value_mem[mem_waddr] <= in_key_value;
        end
        time_rd_reg  <= time_mem[t_addr];
        value_rd_reg <= value_mem[v_addr];
    end

    // component select for the subtract and the final add
    assign res_idx = 2'(mul_cnt_reg - 3'd2);

    always_comb
    begin
        case (mul_cnt_reg[1:0])
            2'd0:    begin a_sub = a_reg[31:0];  b_sub = b_reg[31:0];  end
            2'd1:    begin a_sub = a_reg[63:32]; b_sub = b_reg[63:32]; end
            2'd2:    begin a_sub = a_reg[95:64]; b_sub = b_reg[95:64]; end
            default: begin a_sub = '0;           b_sub = '0;           end
        endcase
    end

    always_comb
    begin
        case (res_idx)
            2'd0:    a_res = a_reg[31:0];
            2'd1:    a_res = a_reg[63:32];
            2'd2:    a_res = a_reg[95:64];
            default: a_res = '0;
        endcase
    end

    assign rem_dbl = {rem_reg, 1'b0};

    // sequencer and shared datapath
    always_comb
    begin
        state_next    = state_reg;
        num_keys_next = num_keys_reg;
        n_next        = n_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        seg_next      = seg_reg;
        prev_next     = prev_reg;
        rem_next      = rem_reg;
        delta_next    = delta_reg;
        quo_next      = quo_reg;
        div_cnt_next  = div_cnt_reg;
        mul_cnt_next  = mul_cnt_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        d_next        = d_reg;
        prod_next     = prod_reg;
        res_next      = res_reg;
        oor_next      = oor_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;

        if (cfg_we)
            num_keys_next = cfg_wdata;

        // output register drains on a transfer
        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer && s_tuser == KIND_QUERY)
                begin
                    n_next   = n_eff;
                    q_next   = in_query_time;
                    cnt_next = '0;
                    seg_next = '0;
                    oor_next = 1'b0;
                    if (n_eff == NW'(1))
                        state_next = ST_FETCH;
                    else
                        state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                // time_rd_reg holds the time of key cnt
                prev_next = time_rd_reg;
                if (cnt_reg == '0 && q_reg < time_rd_reg)
                begin
                    // before the first key
                    seg_next   = '0;
                    oor_next   = 1'b1;
                    state_next = ST_FETCH;
                end
                else if (cnt_reg != '0 && q_reg < time_rd_reg)
                begin
                    // segment found, start the factor divide
                    seg_next     = cnt_reg - IW'(1);
                    rem_next     = q_reg - prev_reg;
                    delta_next   = time_rd_reg - prev_reg;
                    quo_next     = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
                else if (cnt_ext == n_reg - NW'(1))
                begin
                    // at or past the last key
                    seg_next   = cnt_reg;
                    oor_next   = (q_reg > time_rd_reg);
                    state_next = ST_FETCH;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            ST_DIV:
            begin
                // one restoring step per cycle
                if (rem_dbl >= {1'b0, delta_reg})
                begin
                    rem_next = 32'(rem_dbl - {1'b0, delta_reg});
                    quo_next = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_dbl[31:0];
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                // pick up both end values while dividing
                if (div_cnt_reg == 4'd1)
                    a_next = value_rd_reg;
                if (div_cnt_reg == 4'd2)
                    b_next = value_rd_reg;
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'd15)
                begin
                    mul_cnt_next = '0;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // subtract, multiply, add: three stages over the components
                if (mul_cnt_reg < 3'd3)
                    d_next = $signed({b_sub[31], b_sub}) - $signed({a_sub[31], a_sub});
                if (mul_cnt_reg >= 3'd1 && mul_cnt_reg <= 3'd3)
                    prod_next = d_reg * $signed({1'b0, quo_reg});
                if (mul_cnt_reg >= 3'd2)
                    res_next[32*res_idx +: 32] = a_res + prod_reg[47:16];
                mul_cnt_next = mul_cnt_reg + 3'd1;
                if (mul_cnt_reg == 3'd4)
                    state_next = ST_OUT;
            end
            ST_FETCH:
            begin
                // value read of key seg is in flight
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                res_next   = value_rd_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_user_next  = oor_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // register update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            num_keys_reg <= 5'd1;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            num_keys_reg <= num_keys_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        q_reg       <= q_next;
        cnt_reg     <= cnt_next;
        seg_reg     <= seg_next;
        prev_reg    <= prev_next;
        rem_reg     <= rem_next;
        delta_reg   <= delta_next;
        quo_reg     <= quo_next;
        div_cnt_reg <= div_cnt_next;
        mul_cnt_reg <= mul_cnt_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        d_reg       <= d_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
        oor_reg     <= oor_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

endmodule

FILE: tb/tb_keyframe_track_lerp.sv
`timescale 1ns / 1ps

module tb_keyframe_track_lerp
    import kftl_pkg::*;
;

    localparam int TRACK_KEYS    = 16;
    localparam int SETTLE_CYCLES = 60;
    localparam int DRAIN_LIMIT   = 20000;

    // one interpolated sample, laid out as {m_tuser, m_tdata}
    typedef struct packed {
        logic        oor;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } track_sample_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [4:0]             cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    // shadow copy of the track and the key count
    logic [31:0]   trk_time [TRACK_KEYS];
    logic [31:0]   trk_val  [TRACK_KEYS][3];
    logic [4:0]    trk_count;
    track_sample_t pending_samples[$];

    // traffic shaping
    bit sender_bursty;
    int burst_left;
    int rx_mode;
    int rx_tick;

    // run statistics
    int errors;
    int n_writes;
    int n_queries;
    int n_clamped;
    int n_single;
    int n_configs;

    keyframe_track_lerp #(
        .KEYS(TRACK_KEYS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // hard stop if the block hangs
    initial
    begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // number of keys the search actually uses
    function automatic int effective_keys();
        int n;
        n = trk_count;
        if (n < 1)
            n = 1;
        if (n > TRACK_KEYS)
            n = TRACK_KEYS;
        return n;
    endfunction

    function automatic track_sample_t key_sample(int k, logic flag);
        track_sample_t r;
        r.x   = trk_val[k][0];
        r.y   = trk_val[k][1];
        r.z   = trk_val[k][2];
        r.oor = flag;
        return r;
    endfunction

    // start + floor(f * (end - start) / 2^16)
    function automatic logic [31:0] blend_component(logic [31:0] a, logic [31:0] b, longint f);
        longint sa;
        longint sb;
        longint p;
        longint r;
        sa = $signed(a);
        sb = $signed(b);
        p  = (sb - sa) * f;
        r  = sa + (p >>> 16);
        return r[31:0];
    endfunction

    // expected sample for a query at time q
    function automatic track_sample_t interpolate_track(logic [31:0] q);
        int              n;
        int              seg;
        longint unsigned tq;
        longint unsigned t0;
        longint unsigned delta;
        longint unsigned f;
        track_sample_t   r;
        n = effective_keys();
        if (n == 1)
            return key_sample(0, 1'b0);
        if (q < trk_time[0])
            return key_sample(0, 1'b1);
        seg = -1;
        for (int i = 0; i + 1 < n; i++)
        begin
            if (seg < 0 && q < trk_time[i + 1])
                seg = i;
        end
        if (seg < 0)
            return key_sample(n - 1, q > trk_time[n - 1]);
        tq    = q;
        t0    = trk_time[seg];
        delta = trk_time[seg + 1];
        delta = delta - t0;
        f     = ((tq - t0) << 16) / delta;
        if (f > 65535)
            f = 65535;
        r.oor = 1'b0;
        r.x   = blend_component(trk_val[seg][0], trk_val[seg + 1][0], f);
        r.y   = blend_component(trk_val[seg][1], trk_val[seg + 1][1], f);
        r.z   = blend_component(trk_val[seg][2], trk_val[seg + 1][2], f);
        return r;
    endfunction

    // query time mix: mostly inside a segment, some on keys and outside the range
    function automatic logic [31:0] pick_query_time(int n);
        int          sel;
        int          k;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] last;
        sel  = $urandom_range(0, 9);
        last = trk_time[n - 1];
        if (n == 1 || sel == 9)
            return $urandom;
        if (sel == 8)
            return trk_time[$urandom_range(0, n - 1)];
        if (sel == 7)
            return (trk_time[0] == 0) ? 32'h0 : $urandom_range(0, trk_time[0] - 1);
        if (sel == 6)
            return (last == 32'hFFFF_FFFF) ? last : $urandom_range(last + 1, 32'hFFFF_FFFF);
        k  = $urandom_range(0, n - 2);
        lo = trk_time[k];
        hi = trk_time[k + 1];
        if (hi > lo)
            return lo + $urandom_range(0, hi - lo - 1);
        return lo;
    endfunction

    // one input transfer, with bursts and gaps on the sender side
    task automatic send_item(logic kind, logic [3:0] idx, logic [31:0] kt, logic [31:0] kx,
                             logic [31:0] ky, logic [31:0] kz, logic [31:0] qt);
        int            gap;
        track_sample_t pred;
        @(negedge clk);
        if (sender_bursty && burst_left == 0)
        begin
            s_tvalid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 45) : $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {4'b0, qt, kz, ky, kx, kt, idx};
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        // transfer accepted, update the shadow track or queue the sample
        if (kind == KIND_WRITE)
        begin
            trk_time[idx]   = kt;
            trk_val[idx][0] = kx;
            trk_val[idx][1] = ky;
            trk_val[idx][2] = kz;
            n_writes++;
        end
        else
        begin
            pred = interpolate_track(qt);
            pending_samples = {pending_samples, pred};
            n_queries++;
            if (pred.oor)
                n_clamped++;
            if (effective_keys() == 1)
                n_single++;
        end
    endtask

    task automatic write_key(logic [3:0] idx, logic [31:0] t, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
        send_item(KIND_WRITE, idx, t, x, y, z, $urandom);
    endtask

    // unused fields of a query carry random junk
    task automatic query_track(logic [31:0] q);
        send_item(KIND_QUERY, 4'($urandom_range(0, 15)), $urandom, $urandom, $urandom,
                  $urandom, q);
    endtask

    // key count write, only once the block has drained
    task automatic set_key_count(logic [4:0] value);
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        trk_count = value;
        n_configs++;
    endtask

    // full track, extreme values on the first segment, times up to the top of the range
    task automatic test_load_track();
        logic [31:0] t;
        for (int i = 0; i < TRACK_KEYS; i++)
        begin
            t = (i == TRACK_KEYS - 1) ? 32'hFFFF_FFFF : (i << 28) + 32'h100;
            if (i == 0)
                write_key(4'(i), t, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
            else if (i == 1)
                write_key(4'(i), t, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
            else
                write_key(4'(i), t, $urandom, $urandom, $urandom);
        end
    endtask

    // one key returns key 0 whatever the time, count 0 behaves as 1
    task automatic test_single_key();
        set_key_count(5'd1);
        query_track(32'h0);
        query_track(32'hFFFF_FFFF);
        set_key_count(5'd0);
        query_track($urandom);
    endtask

    // before the first key, on keys, full-span segment, at and past the last key
    task automatic test_clamping();
        set_key_count(5'd16);
        query_track(32'h0);
        query_track(32'h100);
        query_track(32'h0800_0000);
        query_track(32'h1000_00FF);
        query_track(32'hFFFF_FFFF);
        set_key_count(5'd4);
        query_track(32'h3000_0100);
        query_track(32'h4000_0000);
    endtask

    // key 2 moved below key 1, search still picks the first later key
    task automatic test_unsorted_keys();
        write_key(4'd2, 32'h0500_0000, $urandom, $urandom, $urandom);
        query_track(32'h0800_0000);
        query_track(32'h2000_0000);
        write_key(4'd2, 32'h2000_0100, $urandom, $urandom, $urandom);
    endtask

    // counts above the table size behave as the full table
    task automatic test_key_count_limits();
        set_key_count(5'd17);
        query_track(32'hF800_0000);
        set_key_count(5'd31);
        query_track(32'hFFFF_FFFF);
    endtask

    // random phases: new count, sorted track, then mostly queries with some rewrites
    task automatic test_random_tracks(int budget);
        int          used;
        int          pick;
        int          n;
        int          k;
        int          step_max;
        int          kind_pick;
        logic [4:0]  count;
        logic [31:0] plan [TRACK_KEYS];
        longint      acc;
        used = 0;
        while (used < budget)
        begin
            pick = $urandom_range(0, 19);
            if (pick <= 16)
                count = 5'(pick);
            else if (pick == 17)
                count = 5'd17;
            else if (pick == 18)
                count = 5'd31;
            else
                count = 5'd16;
            set_key_count(count);
            n = effective_keys();
            sender_bursty = ($urandom_range(0, 3) != 0);
            rx_mode       = $urandom_range(0, 2);
            // ascending times with a random spacing scale, ties allowed
            case ($urandom_range(0, 3))
                0:       step_max = 4;
                1:       step_max = 255;
                2:       step_max = 65535;
                default: step_max = 32'h0FFF_FFFF;
            endcase
            acc = (step_max > 65535) ? $urandom_range(0, 255) : $urandom;
            for (int i = 0; i < TRACK_KEYS; i++)
            begin
                plan[i] = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
                acc = acc + $urandom_range(0, step_max);
            end
            for (int i = 0; i < n; i++)
            begin
                write_key(4'(i), plan[i], $urandom, $urandom, $urandom);
                used++;
            end
            repeat ($urandom_range(20, 60))
            begin
                kind_pick = $urandom_range(0, 99);
                if (kind_pick < 8)
                begin
                    write_key(4'($urandom_range(0, 15)), $urandom, $urandom, $urandom,
                              $urandom);
                end
                else if (kind_pick < 16)
                begin
                    k = $urandom_range(0, n - 1);
                    write_key(4'(k), trk_time[k], $urandom, $urandom, $urandom);
                end
                else
                begin
                    query_track(pick_query_time(n));
                end
                used++;
            end
        end
    endtask

    // receiver stall patterns
    always @(negedge clk)
    begin
        case (rx_mode)
            0:       m_tready = 1'b1;
            1:       m_tready = ($urandom_range(0, 1) == 1);
            default: m_tready = ((rx_tick % 7) > 2);
        endcase
        rx_tick++;
    end

    // compare each output transfer with the oldest expected sample
    always @(posedge clk)
    begin
        track_sample_t got;
        track_sample_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            got = {m_tuser, m_tdata};
            if (pending_samples.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected sample x=%h y=%h z=%h oor=%b",
                             got.x, got.y, got.z, got.oor);
            end
            else
            begin
                want = pending_samples.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                    got.oor !== want.oor)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"sample mismatch: exp x=%h y=%h z=%h oor=%b, ",
                                  "got x=%h y=%h z=%h oor=%b"},
                                 want.x, want.y, want.z, want.oor,
                                 got.x, got.y, got.z, got.oor);
                end
            end
        end
    end

    initial
    begin
        int waited;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 5'd0;
        s_tvalid      = 1'b0;
        s_tuser       = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b1;
        rx_mode       = 0;
        rx_tick       = 0;
        sender_bursty = 1'b0;
        burst_left    = 0;
        errors        = 0;
        trk_count     = 5'd1;
        for (int i = 0; i < TRACK_KEYS; i++)
        begin
            trk_time[i]   = '0;
            trk_val[i][0] = '0;
            trk_val[i][1] = '0;
            trk_val[i][2] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_load_track();
        test_single_key();
        test_clamping();
        test_unsorted_keys();
        test_key_count_limits();
        test_random_tracks(1220);

        // drain the output side
        @(negedge clk);
        s_tvalid = 1'b0;
        waited = 0;
        while (pending_samples.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_samples.size() != 0)
        begin
            errors += pending_samples.size();
            $display("%0d expected samples never came out", pending_samples.size());
        end

        $display("covered %0d key writes and %0d queries over %0d key-count settings",
                 n_writes, n_queries, n_configs);
        $display("of the queries %0d were clamped and %0d ran on a single key",
                 n_clamped, n_single);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
